// File: rtl/core/i2c_master_eeprom_byte_access_assert.svh
// assertion macros shared by the rtl files
`ifndef I2C_MASTER_EEPROM_BYTE_ACCESS_ASSERT_SVH
`define I2C_MASTER_EEPROM_BYTE_ACCESS_ASSERT_SVH

`ifndef SYNTH

// same-cycle implication
`define I2CEE_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define I2CEE_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define I2CEE_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)

`define I2CEE_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

// File: rtl/core/i2cee_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package i2cee_pkg;

    // widths of the fixed fields
    localparam int CMD_W       = 2;
    localparam int BYTE_W      = 8;
    localparam int DEV_ADDR_W  = 7;
    localparam int ACK_W       = 8;
    localparam int CFG_DATA_W  = 16;
    localparam int CFG_INDEX_W = 2;

    // defaults for the top level parameters
    localparam int DELAY_BITS_DEF  = 16;
    localparam int QUEUE_DEPTH_DEF = 4;

    // register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_DEVICE_ADDRESS  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_TICKS_PER_DELAY = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_ACK_TIMEOUT     = 2'd2;

    // register reset values
    localparam logic [DEV_ADDR_W-1:0] DEV_ADDR_RESET    = 7'h50;
    localparam logic [CFG_DATA_W-1:0] TPD_RESET         = 16'd1000;
    localparam logic [ACK_W-1:0]      ACK_TIMEOUT_RESET = 8'd9;

    // command codes on the input word
    localparam logic [CMD_W-1:0] CMD_CODE_WRITE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CODE_READ  = 2'd2;

    // bits in one byte, as a bit counter value
    localparam logic [3:0] BYTE_BITS = 4'd8;

    typedef enum logic [1:0] {
        CMD_TICK,
        CMD_WRITE,
        CMD_READ
    } cmd_t;

    // classified word between front and back
    typedef struct packed {
        cmd_t              cmd;
        logic [BYTE_W-1:0] mem_addr;
        logic [BYTE_W-1:0] write_data;
        logic              sda_in;
    } word_t;

    typedef enum logic [3:0] {
        PH_IDLE,
        PH_START_A,
        PH_START_B,
        PH_BIT_LOW,
        PH_BIT_HIGH,
        PH_ACK_LOW,
        PH_ACK_HIGH,
        PH_RS_LOW,
        PH_RS_HIGH,
        PH_RD_LOW,
        PH_RD_HIGH,
        PH_NACK_LOW,
        PH_NACK_HIGH,
        PH_STOP_A,
        PH_STOP_B,
        PH_STOP_C
    } phase_t;

    // which byte of the transaction is on the bus
    typedef enum logic [1:0] {
        ST_DEV,
        ST_ADDR,
        ST_DATA
    } stage_t;

    typedef struct packed {
        logic              scl_level;
        logic              sda_level;
        logic              busy_res;
        logic              done_res;
        logic [BYTE_W-1:0] read_data;
        logic              ack_error;
    } rsp_t;

endpackage

`default_nettype wire

// File: rtl/core/i2cee_if.sv
`timescale 1ns / 1ps
`default_nettype none

// tick channel into the block
interface i2cee_in_if
    import i2cee_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [CMD_W-1:0]  command;
    logic [BYTE_W-1:0] mem_addr;
    logic [BYTE_W-1:0] write_data;
    logic              sda_in;

    modport source (output valid, output command, output mem_addr, output write_data,
                    output sda_in, input ready);
    modport sink   (input valid, input command, input mem_addr, input write_data,
                    input sda_in, output ready);
endinterface

// bus status channel out of the block
interface i2cee_out_if
    import i2cee_pkg::*;
();
    logic              valid;
    logic              ready;
    logic              scl_level;
    logic              sda_level;
    logic              busy_res;
    logic              done_res;
    logic [BYTE_W-1:0] read_data;
    logic              ack_error;

    modport source (output valid, output scl_level, output sda_level, output busy_res,
                    output done_res, output read_data, output ack_error, input ready);
    modport sink   (input valid, input scl_level, input sda_level, input busy_res,
                    input done_res, input read_data, input ack_error, output ready);
endinterface

`default_nettype wire

// File: rtl/core/i2cee_front.sv
`timescale 1ns / 1ps
`default_nettype none

module i2cee_front
    import i2cee_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    i2cee_in_if.sink tick,
    output logic     push,
    output word_t    push_word,
    input  logic     q_full
);

    logic  hold_valid_reg;
    word_t hold_word_reg;
    word_t class_word;
    logic  accept;

    // take a word whenever the holding register is empty or drains this cycle
    assign tick.ready = !hold_valid_reg || !q_full;
    assign accept     = tick.valid && tick.ready;
    assign push       = hold_valid_reg && !q_full;
    assign push_word  = hold_word_reg;

    // classify the command code, unused codes are plain ticks
    always_comb
    begin
        class_word.mem_addr   = tick.mem_addr;
        class_word.write_data = tick.write_data;
        class_word.sda_in     = tick.sda_in;
        unique case (tick.command)
            CMD_CODE_WRITE: class_word.cmd = CMD_WRITE;
            CMD_CODE_READ:  class_word.cmd = CMD_READ;
            default:        class_word.cmd = CMD_TICK;
        endcase
    end

    // holding register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            hold_valid_reg <= 1'b1;
        end
        else if (push)
        begin
            hold_valid_reg <= 1'b0;
        end
    end

    // holding register payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            hold_word_reg <= class_word;
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/i2cee_queue.sv
`timescale 1ns / 1ps
`default_nettype none

`include "i2c_master_eeprom_byte_access_assert.svh"

module i2cee_queue
    import i2cee_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  word_t push_word,
    output logic  full,
    input  logic  pop,
    output logic  q_valid,
    output word_t head_word
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    word_t             slot_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign q_valid   = (count_reg != '0);
    assign head_word = slot_reg[rd_ptr_reg];

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_word;
        end
    end

    `I2CEE_ASSERT_IMP(a_q_no_overflow, clk, rst_n, push, !full || pop, "push into full queue")
    `I2CEE_ASSERT_IMP(a_q_no_underflow, clk, rst_n, pop, q_valid, "pop from empty queue")

endmodule

`default_nettype wire

// File: rtl/core/i2cee_back.sv
`timescale 1ns / 1ps
`default_nettype none

`include "i2c_master_eeprom_byte_access_assert.svh"

module i2cee_back
    import i2cee_pkg::*;
#(
    parameter int DELAY_BITS = DELAY_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  q_valid,
    input  word_t                 q_word,
    output logic                  q_pop,
    input  logic [DEV_ADDR_W-1:0] device_address,
    input  logic [DELAY_BITS-1:0] ticks_per_delay,
    input  logic [ACK_W-1:0]      ack_timeout,
    i2cee_out_if.source           status
);

    phase_t                phase_reg, phase_next;
    stage_t                stage_reg, stage_next;
    logic [3:0]            bit_count_reg, bit_count_next;
    logic [BYTE_W-1:0]     shift_byte_reg, shift_byte_next;
    logic [DELAY_BITS-1:0] delay_count_reg, delay_count_next;
    logic [ACK_W-1:0]      ack_wait_count_reg, ack_wait_count_next;
    logic [BYTE_W-1:0]     held_addr_reg, held_addr_next;
    logic [BYTE_W-1:0]     held_data_reg, held_data_next;
    logic                  is_read_reg, is_read_next;
    logic [BYTE_W-1:0]     read_byte_reg, read_byte_next;
    logic                  ack_fault_reg, ack_fault_next;
    logic                  done_next;
    logic                  after_ack;

    logic [DELAY_BITS:0]   dc_inc;
    logic [DELAY_BITS:0]   limit;
    logic [3:0]            bc_inc;
    logic [BYTE_W-1:0]     rd_shift;

    logic                  out_valid_reg;
    rsp_t                  rsp_reg, rsp_next;

    // one tick is processed when the output register can take its status
    assign q_pop = q_valid && (!out_valid_reg || status.ready);

    // delay phase length, zero counts as one tick
    assign dc_inc   = {1'b0, delay_count_reg} + (DELAY_BITS + 1)'(1);
    assign limit    = (ticks_per_delay == '0) ? (DELAY_BITS + 1)'(1)
                                              : {1'b0, ticks_per_delay};
    assign bc_inc   = bit_count_reg + 4'd1;
    assign rd_shift = {shift_byte_reg[BYTE_W-2:0], q_word.sda_in};

    // sequencer state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg          <= PH_IDLE;
            stage_reg          <= ST_DEV;
            bit_count_reg      <= '0;
            shift_byte_reg     <= '0;
            delay_count_reg    <= '0;
            ack_wait_count_reg <= '0;
            held_addr_reg      <= '0;
            held_data_reg      <= '0;
            is_read_reg        <= 1'b0;
            read_byte_reg      <= '0;
            ack_fault_reg      <= 1'b0;
        end
        else
        begin
            phase_reg          <= phase_next;
            stage_reg          <= stage_next;
            bit_count_reg      <= bit_count_next;
            shift_byte_reg     <= shift_byte_next;
            delay_count_reg    <= delay_count_next;
            ack_wait_count_reg <= ack_wait_count_next;
            held_addr_reg      <= held_addr_next;
            held_data_reg      <= held_data_next;
            is_read_reg        <= is_read_next;
            read_byte_reg      <= read_byte_next;
            ack_fault_reg      <= ack_fault_next;
        end
    end

    // next state for one tick
    always_comb
    begin
        phase_next          = phase_reg;
        stage_next          = stage_reg;
        bit_count_next      = bit_count_reg;
        shift_byte_next     = shift_byte_reg;
        delay_count_next    = delay_count_reg;
        ack_wait_count_next = ack_wait_count_reg;
        held_addr_next      = held_addr_reg;
        held_data_next      = held_data_reg;
        is_read_next        = is_read_reg;
        read_byte_next      = read_byte_reg;
        ack_fault_next      = ack_fault_reg;
        done_next           = 1'b0;
        after_ack           = 1'b0;

        if (q_pop)
        begin
            if (phase_reg == PH_IDLE)
            begin
                // a command only starts from idle
                if (q_word.cmd != CMD_TICK)
                begin
                    held_addr_next   = q_word.mem_addr;
                    held_data_next   = q_word.write_data;
                    is_read_next     = (q_word.cmd == CMD_READ);
                    ack_fault_next   = 1'b0;
                    stage_next       = ST_DEV;
                    shift_byte_next  = {device_address, 1'b0};
                    bit_count_next   = '0;
                    delay_count_next = '0;
                    phase_next       = PH_START_A;
                end
            end
            else if (dc_inc < limit)
            begin
                delay_count_next = dc_inc[DELAY_BITS-1:0];
            end
            else
            begin
                delay_count_next = '0;
                unique case (phase_reg)
                    PH_IDLE:      phase_next = PH_IDLE;
                    PH_START_A:   phase_next = PH_START_B;
                    PH_START_B:
                    begin
                        bit_count_next = '0;
                        phase_next     = PH_BIT_LOW;
                    end
                    PH_BIT_LOW:   phase_next = PH_BIT_HIGH;
                    PH_BIT_HIGH:
                    begin
                        shift_byte_next = {shift_byte_reg[BYTE_W-2:0], 1'b0};
                        bit_count_next  = bc_inc;
                        if (bc_inc >= BYTE_BITS)
                        begin
                            ack_wait_count_next = '0;
                            phase_next          = PH_ACK_LOW;
                        end
                        else
                        begin
                            phase_next = PH_BIT_LOW;
                        end
                    end
                    PH_ACK_LOW:   phase_next = PH_ACK_HIGH;
                    PH_ACK_HIGH:
                    begin
                        // timeout wins over a late acknowledge
                        if (ack_wait_count_reg == ack_timeout)
                        begin
                            ack_fault_next = 1'b1;
                            after_ack      = 1'b1;
                        end
                        else if (!q_word.sda_in)
                        begin
                            after_ack = 1'b1;
                        end
                        else
                        begin
                            ack_wait_count_next = ack_wait_count_reg + 1'b1;
                        end
                    end
                    PH_RS_LOW:    phase_next = PH_RS_HIGH;
                    PH_RS_HIGH:
                    begin
                        stage_next      = ST_DATA;
                        shift_byte_next = {device_address, 1'b1};
                        bit_count_next  = '0;
                        phase_next      = PH_START_A;
                    end
                    PH_RD_LOW:    phase_next = PH_RD_HIGH;
                    PH_RD_HIGH:
                    begin
                        shift_byte_next = rd_shift;
                        bit_count_next  = bc_inc;
                        if (bc_inc >= BYTE_BITS)
                        begin
                            read_byte_next = rd_shift;
                            phase_next     = PH_NACK_LOW;
                        end
                        else
                        begin
                            phase_next = PH_RD_LOW;
                        end
                    end
                    PH_NACK_LOW:  phase_next = PH_NACK_HIGH;
                    PH_NACK_HIGH: phase_next = PH_STOP_A;
                    PH_STOP_A:    phase_next = PH_STOP_B;
                    PH_STOP_B:    phase_next = PH_STOP_C;
                    PH_STOP_C:
                    begin
                        phase_next = PH_IDLE;
                        done_next  = 1'b1;
                    end
                endcase

                // pick the next byte once an acknowledge slot ends
                if (after_ack)
                begin
                    priority if (stage_reg == ST_DEV)
                    begin
                        stage_next      = ST_ADDR;
                        shift_byte_next = held_addr_reg;
                        bit_count_next  = '0;
                        phase_next      = PH_BIT_LOW;
                    end
                    else if (stage_reg == ST_ADDR && is_read_reg)
                    begin
                        phase_next = PH_RS_LOW;
                    end
                    else if (stage_reg == ST_ADDR)
                    begin
                        stage_next      = ST_DATA;
                        shift_byte_next = held_data_reg;
                        bit_count_next  = '0;
                        phase_next      = PH_BIT_LOW;
                    end
                    else if (stage_reg == ST_DATA && is_read_reg)
                    begin
                        shift_byte_next = '0;
                        bit_count_next  = '0;
                        phase_next      = PH_RD_LOW;
                    end
                    else
                    begin
                        phase_next = PH_STOP_A;
                    end
                end
            end
        end
    end

    // bus levels and status after the tick
    always_comb
    begin
        rsp_next.busy_res  = (phase_next != PH_IDLE);
        rsp_next.done_res  = done_next;
        rsp_next.read_data = read_byte_next;
        rsp_next.ack_error = ack_fault_next;
        unique case (phase_next)
            PH_START_A:
            begin
                rsp_next.scl_level = 1'b1;
                rsp_next.sda_level = 1'b0;
            end
            PH_START_B, PH_STOP_A:
            begin
                rsp_next.scl_level = 1'b0;
                rsp_next.sda_level = 1'b0;
            end
            PH_BIT_LOW:
            begin
                rsp_next.scl_level = 1'b0;
                rsp_next.sda_level = shift_byte_next[BYTE_W-1];
            end
            PH_BIT_HIGH:
            begin
                rsp_next.scl_level = 1'b1;
                rsp_next.sda_level = shift_byte_next[BYTE_W-1];
            end
            PH_STOP_B:
            begin
                rsp_next.scl_level = 1'b1;
                rsp_next.sda_level = 1'b0;
            end
            PH_ACK_LOW, PH_RS_LOW, PH_RD_LOW, PH_NACK_LOW:
            begin
                rsp_next.scl_level = 1'b0;
                rsp_next.sda_level = 1'b1;
            end
            default:
            begin
                rsp_next.scl_level = 1'b1;
                rsp_next.sda_level = 1'b1;
            end
        endcase
    end

    // output register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (q_pop)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (status.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // output register payload
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign status.valid     = out_valid_reg;
    assign status.scl_level = rsp_reg.scl_level;
    assign status.sda_level = rsp_reg.sda_level;
    assign status.busy_res  = rsp_reg.busy_res;
    assign status.done_res  = rsp_reg.done_res;
    assign status.read_data = rsp_reg.read_data;
    assign status.ack_error = rsp_reg.ack_error;

    `I2CEE_ASSERT_IMP(a_stall_no_step, clk, rst_n, out_valid_reg && !status.ready, !q_pop, "tick processed while status word stalled")
    `I2CEE_ASSERT_IMP(a_bit_count_range, clk, rst_n, 1'b1, bit_count_reg <= BYTE_BITS, "bit counter past one byte")
    `I2CEE_ASSERT_IMP(a_done_not_busy, clk, rst_n, out_valid_reg && rsp_reg.done_res, !rsp_reg.busy_res, "done reported while busy")

endmodule

`default_nettype wire

// File: rtl/core/i2c_master_eeprom_byte_access.sv
// channel   | dir | handshake     | word
// ----------+-----+---------------+----------------------------------------------
// tick      | in  | valid/ready   | command, mem_addr, write_data, sda_in
// status    | out | valid/ready   | scl_level, sda_level, busy_res, done_res,
//           |     |               | read_data, ack_error
// cfg       | in  | cfg_we only   | cfg_index, cfg_data
//
// one tick word is taken and one status word is produced every cycle while status words are accepted
// a tick passes through the front holding register, a queue slot and the status register
// the bus sequencer computes the whole update for one tick combinationally into the status register
// reset clears the sequencer to idle and loads the register defaults
// a stalled status word stops the sequencer; the queue and front register
// keep taking ticks until they fill
`timescale 1ns / 1ps
`default_nettype none

module i2c_master_eeprom_byte_access
    import i2cee_pkg::*;
#(
    parameter int DELAY_BITS  = DELAY_BITS_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    i2cee_in_if.sink               tick,
    i2cee_out_if.source            status,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    logic [DEV_ADDR_W-1:0] device_address_reg;
    logic [DELAY_BITS-1:0] ticks_per_delay_reg;
    logic [ACK_W-1:0]      ack_timeout_reg;

    logic  push;
    word_t push_word;
    logic  q_full;
    logic  q_pop;
    logic  q_valid;
    word_t head_word;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            device_address_reg  <= DEV_ADDR_RESET;
            ticks_per_delay_reg <= DELAY_BITS'(TPD_RESET);
            ack_timeout_reg     <= ACK_TIMEOUT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_DEVICE_ADDRESS:  device_address_reg  <= cfg_data[DEV_ADDR_W-1:0];
                CFG_TICKS_PER_DELAY: ticks_per_delay_reg <= DELAY_BITS'(cfg_data);
                CFG_ACK_TIMEOUT:     ack_timeout_reg     <= cfg_data[ACK_W-1:0];
                default:             ack_timeout_reg     <= ack_timeout_reg;
            endcase
        end
    end

    // accept and classify
    i2cee_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .tick      (tick),
        .push      (push),
        .push_word (push_word),
        .q_full    (q_full)
    );

    // decoupling queue
    i2cee_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_word (push_word),
        .full      (q_full),
        .pop       (q_pop),
        .q_valid   (q_valid),
        .head_word (head_word)
    );

    // bus sequencer
    i2cee_back #(
        .DELAY_BITS (DELAY_BITS)
    ) u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .q_valid         (q_valid),
        .q_word          (head_word),
        .q_pop           (q_pop),
        .device_address  (device_address_reg),
        .ticks_per_delay (ticks_per_delay_reg),
        .ack_timeout     (ack_timeout_reg),
        .status          (status)
    );

endmodule

`default_nettype wire
